### src/tspr_pkg.sv
// Shared types and constants for the tile/sprite pixel renderer.
// No dependencies; imported by every module of the block.
`default_nettype none
package tspr_pkg;

    localparam int SPRITE_COUNT_DEF = 40;
    localparam int SCREEN_WIDTH_DEF = 160;

    localparam int VRAM_AW   = 13;
    localparam int OAM_BYTES = 160;
    localparam int OAM_WORDS = 40;
    localparam int OAM_AW    = 6;
    localparam int CFG_AW    = 5;

    typedef enum logic [1:0] {
        CMD_VRAM_WR = 2'd0,
        CMD_OAM_WR  = 2'd1,
        CMD_RENDER  = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LCDC = 3'd0,
        REG_SCY  = 3'd1,
        REG_SCX  = 3'd2,
        REG_WY   = 3'd3,
        REG_WX   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_VRAM   = 2'd0,
        OP_OAM    = 2'd1,
        OP_RENDER = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [VRAM_AW-1:0]   addr;
        logic [7:0]           data;
        logic [7:0]           line;
        logic [7:0]           column;
    } item_t;

    typedef struct packed {
        logic [7:0] lcdc;
        logic [7:0] scy;
        logic [7:0] scx;
        logic [7:0] wy;
        logic [7:0] wx;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BMAP,
        ST_BLO,
        ST_BHI,
        ST_BEND,
        ST_SOAM,
        ST_SCHK,
        ST_SLO,
        ST_SHI,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

### src/tspr_front.sv
// Command front end: takes commands, drops ones with no effect, and queues
// the rest for the render engine. Depends on tspr_pkg.
`default_nettype none
module tspr_front
    import tspr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic [VRAM_AW-1:0] mem_address,
    input  wire logic [7:0]         mem_data,
    input  wire logic [7:0]         line,
    input  wire logic [7:0]         column,
    input  wire back_status_t       status,
    output logic                    q_valid,
    output item_t                   q_item,
    input  wire logic               q_pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       keep;
    item_t      in_item;

    assign busy    = (count_reg == 2'd2) || status.clearing;
    assign accept  = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        in_item.addr   = mem_address;
        in_item.data   = mem_data;
        in_item.line   = line;
        in_item.column = column;
        keep           = 1'b0;
        in_item.op     = OP_RENDER;
        unique case (cmd_t'(command))
            CMD_VRAM_WR:
            begin
                in_item.op = OP_VRAM;
                keep       = 1'b1;
            end
            CMD_OAM_WR:
            begin
                in_item.op = OP_OAM;
                keep       = ({1'b0, mem_address} < 14'(OAM_BYTES));
            end
            CMD_RENDER:
            begin
                in_item.op = OP_RENDER;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && keep)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        count_next = count_reg + 2'(accept && keep) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

### src/tspr_back.sv
// Render engine: holds video and object memory, performs writes and walks
// background, window and sprite fetches for each pixel. Depends on tspr_pkg.
`default_nettype none
module tspr_back
    import tspr_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output back_status_t status,
    output logic       strobe,
    output logic [1:0] shade,
    output logic [7:0] out_line,
    output logic [7:0] out_column
);

    localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

    logic [7:0]  vram [2**VRAM_AW];
    logic [31:0] oam  [OAM_WORDS];

    state_t state_reg, state_next;

    logic [VRAM_AW-1:0] clr_reg;
    logic [7:0]         vram_rd_reg;
    logic [31:0]        oam_rd_reg;
    logic [VRAM_AW-1:0] vram_ra;
    logic [OAM_AW-1:0]  oam_ra;
    logic               vram_we;
    logic               oam_we;

    logic [7:0]         line_reg, col_reg, ty_reg, tx_reg, lo_reg;
    logic               map_sel_reg, win_next_reg;
    logic [1:0]         shade_reg;
    logic [VRAM_AW-1:0] ta_reg;
    logic [2:0]         bit_reg;
    logic [SW-1:0]      spr_reg;

    // render setup
    logic       beyond, win_hit;
    logic [7:0] wx_eff;
    // tile fetch
    logic [VRAM_AW-1:0] map_addr, tile_addr;
    logic [VRAM_AW-1:0] tile_base;
    logic [1:0]         pix;
    // sprite test
    logic [7:0]         py, px, s_row8, s_dx8, s_tile;
    logic [4:0]         height;
    logic               y_hit, x_hit, s_hit;
    logic [3:0]         s_row;
    logic [VRAM_AW-1:0] s_addr;
    logic [2:0]         s_bit;
    logic               last_spr;

    assign wx_eff  = (cfg.wx > 8'd7) ? (cfg.wx - 8'd7) : 8'd0;
    assign beyond  = ({1'b0, q_item.column} >= 9'(SCREEN_WIDTH));
    assign win_hit = cfg.lcdc[5] && (q_item.line >= cfg.wy) && (q_item.column >= wx_eff);

    assign map_addr  = {2'b11, map_sel_reg, ty_reg[7:3], tx_reg[7:3]};
    assign tile_base = cfg.lcdc[4] ? {1'b0, vram_rd_reg, 4'b0000}
                                   : (13'h0800 + {1'b0, vram_rd_reg ^ 8'h80, 4'b0000});
    assign tile_addr = tile_base | {9'd0, ty_reg[2:0], 1'b0};
    assign pix       = {vram_rd_reg[bit_reg], lo_reg[bit_reg]};

    assign height = cfg.lcdc[2] ? 5'd16 : 5'd8;
    assign py     = oam_rd_reg[7:0] - 8'd16;
    assign px     = oam_rd_reg[15:8] - 8'd8;
    assign y_hit  = (py <= line_reg) && ({1'b0, line_reg} < ({1'b0, py} + 9'(height)));
    assign x_hit  = (px <= col_reg) && ({1'b0, col_reg} < ({1'b0, px} + 9'd8));
    assign s_hit  = y_hit && x_hit;
    assign s_row8 = line_reg - py;
    assign s_dx8  = col_reg - px;
    assign s_tile = cfg.lcdc[2] ? {oam_rd_reg[23:17], 1'b0} : oam_rd_reg[23:16];
    assign last_spr = (spr_reg == SW'(SPRITE_COUNT - 1));

    always_comb
    begin
        s_row = s_row8[3:0];
        if (oam_rd_reg[30])
        begin
            s_row = cfg.lcdc[2] ? ~s_row8[3:0] : {1'b0, ~s_row8[2:0]};
        end
        s_bit  = oam_rd_reg[29] ? s_dx8[2:0] : ~s_dx8[2:0];
        s_addr = {1'b0, s_tile, 4'b0000} + {8'd0, s_row, 1'b0};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && (q_item.op == OP_RENDER))
                begin
                    if (beyond)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (cfg.lcdc[7])
                    begin
                        state_next = ST_BMAP;
                    end
                    else if (cfg.lcdc[1])
                    begin
                        state_next = ST_SOAM;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_BMAP: state_next = ST_BLO;
            ST_BLO:  state_next = ST_BHI;
            ST_BHI:  state_next = ST_BEND;
            ST_BEND:
            begin
                if (win_next_reg)
                begin
                    state_next = ST_BMAP;
                end
                else if (cfg.lcdc[1])
                begin
                    state_next = ST_SOAM;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_SOAM: state_next = ST_SCHK;
            ST_SCHK:
            begin
                if (s_hit)
                begin
                    state_next = ST_SLO;
                end
                else
                begin
                    state_next = last_spr ? ST_OUT : ST_SOAM;
                end
            end
            ST_SLO: state_next = ST_SHI;
            ST_SHI: state_next = last_spr ? ST_OUT : ST_SOAM;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop   = 1'b0;
        vram_we = 1'b0;
        oam_we  = 1'b0;
        vram_ra = map_addr;
        oam_ra  = OAM_AW'(spr_reg);
        strobe  = 1'b0;
        status.clearing = 1'b0;
        status.idle     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                status.clearing = 1'b1;
            end
            ST_IDLE:
            begin
                status.idle = 1'b1;
                q_pop       = q_valid;
                vram_we     = q_valid && (q_item.op == OP_VRAM);
                oam_we      = q_valid && (q_item.op == OP_OAM);
            end
            ST_BMAP: vram_ra = map_addr;
            ST_BLO:  vram_ra = tile_addr;
            ST_BHI:  vram_ra = ta_reg + 13'd1;
            ST_SCHK: vram_ra = s_addr;
            ST_SLO:  vram_ra = ta_reg + 13'd1;
            ST_OUT:  strobe = 1'b1;
            default:
            begin
                vram_ra = map_addr;
            end
        endcase
    end

    assign shade      = shade_reg;
    assign out_line   = line_reg;
    assign out_column = col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 13'd1;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            vram[clr_reg] <= 8'd0;
        end
        else if (vram_we)
        begin
            vram[q_item.addr] <= q_item.data;
        end
        vram_rd_reg <= vram[vram_ra];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CLEAR) && ({7'd0, clr_reg[OAM_AW-1:0]} < 13'(OAM_WORDS))
            && (clr_reg[VRAM_AW-1:OAM_AW] == '0))
        begin
            oam[clr_reg[OAM_AW-1:0]] <= 32'd0;
        end
        else if (oam_we)
        begin
            oam[q_item.addr[OAM_AW+1:2]][q_item.addr[1:0]*8 +: 8] <= q_item.data;
        end
        oam_rd_reg <= oam[oam_ra];
    end

    // pixel datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                line_reg     <= q_item.line;
                col_reg      <= q_item.column;
                shade_reg    <= 2'd0;
                ty_reg       <= q_item.line + cfg.scy;
                tx_reg       <= q_item.column + cfg.scx;
                map_sel_reg  <= cfg.lcdc[3];
                win_next_reg <= win_hit;
                spr_reg      <= '0;
            end
            ST_BLO:
            begin
                ta_reg  <= tile_addr;
                bit_reg <= ~tx_reg[2:0];
            end
            ST_BHI:
            begin
                lo_reg <= vram_rd_reg;
            end
            ST_BEND:
            begin
                shade_reg    <= pix;
                ty_reg       <= line_reg - cfg.wy;
                tx_reg       <= col_reg - wx_eff;
                map_sel_reg  <= cfg.lcdc[6];
                win_next_reg <= 1'b0;
            end
            ST_SCHK:
            begin
                ta_reg  <= s_addr;
                bit_reg <= s_bit;
                if (!s_hit)
                begin
                    spr_reg <= spr_reg + SW'(1);
                end
            end
            ST_SLO:
            begin
                lo_reg <= vram_rd_reg;
            end
            ST_SHI:
            begin
                if (pix != 2'd0)
                begin
                    shade_reg <= pix;
                end
                spr_reg <= spr_reg + SW'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

### src/tile_sprite_pixel_renderer_unit.sv
// Top level of the tile/sprite pixel renderer: APB register file, command
// front end and render engine. Depends on tspr_pkg, tspr_front, tspr_back.
//
// After reset the unit holds busy high while it zeroes video and object
// memory. A command is a transfer at a clock edge with start high and busy
// low. Memory writes retire in the engine's idle state. With the background
// on, a render fetches the map entry and the two bytes of its tile row, and
// again for the window where it covers the pixel; with sprites on, it then
// reads each sprite slot in turn and fetches two tile bytes per sprite
// covering the pixel, paced by the single read port of video memory. A
// two-deep queue lets commands arrive while a render runs. Each render gives
// one result on strobe for a single cycle; the receiver cannot stall it.
`default_nettype none
module tile_sprite_pixel_renderer_unit
    import tspr_pkg::*;
#(
    parameter int SPRITE_COUNT = SPRITE_COUNT_DEF,
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic [VRAM_AW-1:0] mem_address,
    input  wire logic [7:0]         mem_data,
    input  wire logic [7:0]         line,
    input  wire logic [7:0]         column,
    output logic                    strobe,
    output logic [1:0]              shade,
    output logic [7:0]              out_line,
    output logic [7:0]              out_column,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t         cfg_reg;
    logic         cfg_wr;
    logic         q_valid, q_pop;
    item_t        q_item;
    back_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_LCDC: cfg_reg.lcdc <= pwdata[7:0];
                REG_SCY:  cfg_reg.scy  <= pwdata[7:0];
                REG_SCX:  cfg_reg.scx  <= pwdata[7:0];
                REG_WY:   cfg_reg.wy   <= pwdata[7:0];
                REG_WX:   cfg_reg.wx   <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_LCDC: prdata = {24'd0, cfg_reg.lcdc};
            REG_SCY:  prdata = {24'd0, cfg_reg.scy};
            REG_SCX:  prdata = {24'd0, cfg_reg.scx};
            REG_WY:   prdata = {24'd0, cfg_reg.wy};
            REG_WX:   prdata = {24'd0, cfg_reg.wx};
            default:  prdata = 32'd0;
        endcase
    end

    tspr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .mem_address (mem_address),
        .mem_data    (mem_data),
        .line        (line),
        .column      (column),
        .status      (status),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    tspr_back #(
        .SPRITE_COUNT (SPRITE_COUNT),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .status     (status),
        .strobe     (strobe),
        .shade      (shade),
        .out_line   (out_line),
        .out_column (out_column)
    );

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("result strobe held two cycles");

    a_offscreen_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && ({1'b0, out_column} >= 9'(SCREEN_WIDTH))) |-> (shade == 2'd0))
        else $error("off-screen pixel not blank");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> (busy && !strobe))
        else $error("activity during memory clear");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && status.idle))
        else $error("queue popped outside idle");

endmodule
`default_nettype wire

### tb/tile_sprite_pixel_renderer_unit_test.sv
// Self-checking testbench for tile_sprite_pixel_renderer_unit: drives memory writes and
// pixel renders, predicts each pixel shade from a local copy of memory and registers.
// Depends on tspr_pkg and the unit RTL.
`default_nettype none

class pixel_scoreboard;
    logic [7:0] vmem [0:8191];
    logic [7:0] omem [0:159];
    logic [7:0] lcdc, scy, scx, wy, wx;
    logic [1:0] exp_shade [$];
    logic [7:0] exp_line [$];
    logic [7:0] exp_col [$];
    int errors;

    function new();
        for (int i = 0; i < 8192; i++) vmem[i] = 8'd0;
        for (int i = 0; i < 160; i++) omem[i] = 8'd0;
        lcdc = 0; scy = 0; scx = 0; wy = 0; wx = 0;
        errors = 0;
    endfunction

    function logic [1:0] plane(logic [12:0] a, int b);
        logic [12:0] a1;
        a1 = a + 13'd1;
        return {vmem[a1][b], vmem[a][b]};
    endfunction

    function logic [1:0] tile_px(logic [12:0] map, logic [7:0] y, logic [7:0] x);
        logic [7:0] idx;
        logic [12:0] base;
        idx = vmem[map + {y[7:3], 5'd0} + x[7:3]];
        if (lcdc[4]) base = {1'b0, idx, 4'd0};
        else base = 13'h0800 + {1'b0, idx ^ 8'h80, 4'd0};
        return plane(base + {y[2:0], 1'b0}, 7 - x[2:0]);
    endfunction

    function logic [1:0] shade_of(int ln, int col);
        logic [1:0] s;
        int wxs, height, py, px, row, dx, bt;
        logic [7:0] tile;
        logic [1:0] c;
        s = 0;
        if (col >= 160) return 0;
        if (lcdc[7]) begin
            s = tile_px(lcdc[3] ? 13'h1C00 : 13'h1800, 8'(ln + scy), 8'(col + scx));
            if (lcdc[5] && ln >= wy) begin
                wxs = (wx > 7) ? wx - 7 : 0;
                if (col >= wxs)
                    s = tile_px(lcdc[6] ? 13'h1C00 : 13'h1800, 8'(ln - wy), 8'(col - wxs));
            end
        end
        if (lcdc[1]) begin
            height = lcdc[2] ? 16 : 8;
            for (int i = 0; i < 40; i++) begin
                py = (omem[i*4] - 16) & 255;
                px = (omem[i*4+1] - 8) & 255;
                tile = omem[i*4+2];
                if (py <= ln && ln < py + height && px <= col && col < px + 8) begin
                    row = ln - py;
                    if (omem[i*4+3][6]) row = height - 1 - row;
                    if (height == 16) tile[0] = 1'b0;
                    dx = col - px;
                    bt = omem[i*4+3][5] ? dx : 7 - dx;
                    c = plane(13'({tile, 4'd0} + row * 2), bt);
                    if (c != 0) s = c;
                end
            end
        end
        return s;
    endfunction

    function void note_input(logic [1:0] cmd, logic [12:0] a, logic [7:0] d,
                             logic [7:0] ln, logic [7:0] col);
        if (cmd == tspr_pkg::CMD_VRAM_WR) vmem[a] = d;
        else if (cmd == tspr_pkg::CMD_OAM_WR) begin
            if (a < 160) omem[a] = d;
        end else if (cmd == tspr_pkg::CMD_RENDER) begin
            exp_shade.push_back(shade_of(ln, col));
            exp_line.push_back(ln);
            exp_col.push_back(col);
        end
    endfunction

    function void check_result(logic [1:0] s, logic [7:0] ln, logic [7:0] col);
        logic [1:0] es;
        logic [7:0] el, ec;
        if (exp_shade.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pixel line %0d col %0d", ln, col);
            return;
        end
        es = exp_shade.pop_front();
        el = exp_line.pop_front();
        ec = exp_col.pop_front();
        if (s !== es || ln !== el || col !== ec) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp shade %0d line %0d col %0d, got %0d %0d %0d",
                         es, el, ec, s, ln, col);
        end
    endfunction
endclass

module tile_sprite_pixel_renderer_unit_test;
    import tspr_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] command = 0;
    logic [VRAM_AW-1:0] mem_address = 0;
    logic [7:0] mem_data = 0, line = 0, column = 0;
    logic strobe;
    logic [1:0] shade;
    logic [7:0] out_line, out_column;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [CFG_AW-1:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;
    bit gaps = 1;
    pixel_scoreboard sb;

    tile_sprite_pixel_renderer_unit dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        if (strobe) sb.check_result(shade, out_line, out_column);

    task automatic write_reg(reg_idx_t r, logic [7:0] v);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= CFG_AW'(r * 4); pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (r)
            REG_LCDC: sb.lcdc = v;
            REG_SCY:  sb.scy = v;
            REG_SCX:  sb.scx = v;
            REG_WY:   sb.wy = v;
            default:  sb.wx = v;
        endcase
    endtask

    // called at a rising edge; leaves start high after the transfer so the
    // next item can follow without a gap
    task automatic issue(logic [1:0] cmd, logic [12:0] a, logic [7:0] d,
                         logic [7:0] ln, logic [7:0] col);
        while (gaps && $urandom_range(99) < 33) begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1; command <= cmd; mem_address <= a; mem_data <= d;
        line <= ln; column <= col;
        do @(posedge clk); while (busy);
        sb.note_input(cmd, a, d, ln, col);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.exp_shade.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic set_regs(logic [7:0] l, logic [7:0] sy, logic [7:0] sx,
                            logic [7:0] y, logic [7:0] x);
        drain();
        write_reg(REG_LCDC, l); write_reg(REG_SCY, sy); write_reg(REG_SCX, sx);
        write_reg(REG_WY, y); write_reg(REG_WX, x);
    endtask

    task automatic rand_item();
        int k;
        logic [12:0] a;
        k = $urandom_range(99);
        if (k < 30) begin
            a = ($urandom_range(3) == 0) ? 13'h1800 + 13'($urandom_range(2047))
                                         : 13'($urandom_range(8191));
            issue(CMD_VRAM_WR, a, 8'($urandom), 0, 0);
        end else if (k < 45) begin
            a = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(159));
            issue(CMD_OAM_WR, a, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (k < 48) begin
            issue(CMD_NONE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            issue(CMD_RENDER, 13'($urandom), 8'($urandom),
                  ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(143)),
                  ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(159)));
        end
    endtask

    initial begin
        #20000000;
        $display("FAIL tile_sprite_pixel_renderer_unit");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        // directed
        issue(CMD_RENDER, 0, 0, 0, 0);
        set_regs(8'hFF, 8'd0, 8'd0, 8'd0, 8'd0);
        issue(CMD_VRAM_WR, 13'h0000, 8'hFF, 0, 0);
        issue(CMD_VRAM_WR, 13'h0001, 8'hAA, 0, 0);
        issue(CMD_VRAM_WR, 13'h1FFF, 8'h55, 0, 0);
        issue(CMD_VRAM_WR, 13'h1000, 8'h0F, 0, 0);
        issue(CMD_OAM_WR, 13'd0, 8'd16, 0, 0);
        issue(CMD_OAM_WR, 13'd1, 8'd8, 0, 0);
        issue(CMD_OAM_WR, 13'd2, 8'd1, 0, 0);
        issue(CMD_OAM_WR, 13'd3, 8'h60, 0, 0);
        issue(CMD_OAM_WR, 13'd159, 8'hFF, 0, 0);
        issue(CMD_OAM_WR, 13'd160, 8'h12, 0, 0);
        issue(CMD_OAM_WR, 13'h1FFF, 8'h34, 0, 0);
        issue(CMD_NONE, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
        issue(CMD_RENDER, 0, 0, 8'd0, 8'd0);
        issue(CMD_RENDER, 0, 0, 8'd15, 8'd7);
        issue(CMD_RENDER, 0, 0, 8'd143, 8'd159);
        issue(CMD_RENDER, 0, 0, 8'd255, 8'd160);
        issue(CMD_RENDER, 0, 0, 8'd7, 8'd255);
        set_regs(8'h06, 8'd255, 8'd255, 8'd255, 8'd255);
        issue(CMD_RENDER, 0, 0, 8'd8, 8'd3);
        issue(CMD_RENDER, 0, 0, 8'd0, 8'd0);
        set_regs(8'hA0, 8'd3, 8'd5, 8'd10, 8'd3);
        issue(CMD_RENDER, 0, 0, 8'd9, 8'd0);
        issue(CMD_RENDER, 0, 0, 8'd10, 8'd0);
        // random, several register phases
        for (int p = 0; p < 8; p++) begin
            if (p == 7) set_regs(8'h00, 8'd0, 8'd0, 8'd0, 8'd0);
            else set_regs(8'($urandom) | 8'h80, 8'($urandom), 8'($urandom),
                          8'($urandom_range(150)), 8'($urandom_range(170)));
            gaps = (p != 3);
            for (int n = 0; n < 85; n++) rand_item();
        end
        drain();
        if (sb.exp_shade.size() == 0 && sb.errors == 0)
            $display("PASS tile_sprite_pixel_renderer_unit");
        else
            $display("FAIL tile_sprite_pixel_renderer_unit");
        $finish;
    end
endmodule
